>>> hdl/ddpi_pkg.sv
package ddpi_pkg;

  // Field widths
  localparam int unsigned SLOT_W = 2;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned HEAD_W = 16;
  localparam int unsigned SPD_W  = 16;
  localparam int unsigned RATE_W = 16;
  localparam int unsigned TICK_W = 10;
  localparam int unsigned THR_W  = 15;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 15;

  localparam int unsigned NUM_SLOTS_DEF = 4;

  // Shared serial units
  localparam int unsigned MUL_AW = 48;
  localparam int unsigned MUL_BW = 34;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned DIV_NW = 48;
  localparam int unsigned DIV_DW = 16;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] n;
    logic [DIV_DW-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  typedef enum logic [0:0] {
    OP_ADVANCE = 1'b0,
    OP_PLACE   = 1'b1
  } opcode_e;

  localparam logic [CFG_IW-1:0] CFG_TICK = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_THR  = 2'd1;

  localparam logic [TICK_W-1:0] TICK_RESET = 10'd10;
  localparam logic [THR_W-1:0]  THR_RESET  = 15'd640;

  // Arithmetic constants
  localparam logic [30:0]       ONE_Q30     = 31'd1073741824;
  localparam logic [MUL_BW-1:0] HALF_PI_Q32 = 34'd6746518852;
  localparam logic [MUL_BW-1:0] NINETY_PI   = 34'd117342;
  localparam logic [DIV_DW-1:0] K_5625      = 16'd5625;
  localparam logic [DIV_NW-1:0] RND_5625    = 48'd2812;
  localparam logic [DIV_DW-1:0] K_125       = 16'd125;
  localparam logic [PROD_W-1:0] RND_STR     = 64'd2097152000;
  localparam logic [PROD_W-1:0] RND_SIN     = 64'd2147483648;
  localparam logic [DIV_DW-1:0] K_72        = 16'd72;
  localparam logic [DIV_DW-1:0] K_42        = 16'd42;
  localparam logic [DIV_DW-1:0] K_20        = 16'd20;
  localparam logic [DIV_DW-1:0] K_6         = 16'd6;
  localparam logic [DIV_DW-1:0] K_90        = 16'd90;
  localparam logic [DIV_DW-1:0] K_56        = 16'd56;
  localparam logic [DIV_DW-1:0] K_30        = 16'd30;
  localparam logic [DIV_DW-1:0] K_12        = 16'd12;

  localparam logic [POS_W-1:0]  SLOT0_X = 32'hFFE98000;
  localparam logic [POS_W-1:0]  SLOT1_X = 32'h00168000;
  localparam logic [HEAD_W-1:0] SLOT1_H = 16'h8000;

  function automatic logic [POS_W-1:0] slot_x_rst(int unsigned i);
    logic [POS_W-1:0] r;
    r = '0;
    if (i == 0) r = SLOT0_X;
    else if (i == 1) r = SLOT1_X;
    return r;
  endfunction

  function automatic logic [HEAD_W-1:0] slot_h_rst(int unsigned i);
    return (i == 1) ? SLOT1_H : '0;
  endfunction

endpackage

>>> hdl/ddpi_mul.sv
module ddpi_mul
  import ddpi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic              busy_q;
  logic [PROD_W-1:0] a_q;
  logic [MUL_BW-1:0] b_q;
  logic [PROD_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (busy_q && (b_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  // one multiplier bit per cycle, stop once the remaining bits are zero
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= PROD_W'(req_i.a);
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      acc_q <= acc_q + (b_q[0] ? a_q : '0);
      a_q   <= {a_q[PROD_W-2:0], 1'b0};
      b_q   <= {1'b0, b_q[MUL_BW-1:1]};
    end
  end

  assign rsp_o.done = busy_q && (b_q == '0);
  assign rsp_o.prod = acc_q;

endmodule

>>> hdl/ddpi_div.sv
module ddpi_div
  import ddpi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NW + 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_NW-1:0] nq_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] d_q;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_q, nq_q[DIV_NW-1]};
  assign fits  = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIV_NW);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 1'b1;
    end
  end

  // restoring division, quotient bits shift in behind the dividend
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      nq_q  <= req_i.n;
      d_q   <= req_i.d;
      rem_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= fits ? DIV_DW'(trial - {1'b0, d_q}) : trial[DIV_DW-1:0];
      nq_q  <= {nq_q[DIV_NW-2:0], fits};
    end
  end

  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.quo  = nq_q;

endmodule

>>> hdl/differential_drive_pose_integrator_unit.sv
// Dead-reckoning pose keeper for NUM_SLOTS robots: a place word loads a slot's pose, an
// advance word moves it by one tick along a straight line or an exact arc and every word
// returns the slot's new pose. One word is worked on at a time. All products and quotients
// come from one bit-serial multiplier (one multiplier bit per cycle) and one restoring
// divider (one quotient bit per cycle), driven by a step sequencer. A place word, or a
// word for a slot beyond NUM_SLOTS, skips the sequencer; a straight-line advance
// evaluates the sine and cosine series once and an arc advance twice. A new word is
// taken as soon as the previous one is finished, while its result still waits in the
// output register.
module differential_drive_pose_integrator_unit
  import ddpi_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IW-1:0]        cfg_index_i,
  input  logic [CFG_DW-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [0:0]               opcode_i,
  input  logic [SLOT_W-1:0]        robot_slot_i,
  input  logic signed [SPD_W-1:0]  speed_i,
  input  logic signed [RATE_W-1:0] turn_rate_i,
  input  logic signed [POS_W-1:0]  place_x_i,
  input  logic signed [POS_W-1:0]  place_y_i,
  input  logic [HEAD_W-1:0]        place_heading_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SLOT_W-1:0]        result_slot_o,
  output logic signed [POS_W-1:0]  pose_x_o,
  output logic signed [POS_W-1:0]  pose_y_o,
  output logic [HEAD_W-1:0]        pose_heading_o
);

  localparam int unsigned SLOT_IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  localparam logic [4:0] STP_WT  = 5'd0;
  localparam logic [4:0] STP_DH  = 5'd1;
  localparam logic [4:0] STP_X   = 5'd2;
  localparam logic [4:0] STP_X2  = 5'd3;
  localparam logic [4:0] STP_S1  = 5'd4;
  localparam logic [4:0] STP_S2M = 5'd5;
  localparam logic [4:0] STP_S2D = 5'd6;
  localparam logic [4:0] STP_S3M = 5'd7;
  localparam logic [4:0] STP_S3D = 5'd8;
  localparam logic [4:0] STP_S4M = 5'd9;
  localparam logic [4:0] STP_S4D = 5'd10;
  localparam logic [4:0] STP_SIN = 5'd11;
  localparam logic [4:0] STP_C1  = 5'd12;
  localparam logic [4:0] STP_C2M = 5'd13;
  localparam logic [4:0] STP_C2D = 5'd14;
  localparam logic [4:0] STP_C3M = 5'd15;
  localparam logic [4:0] STP_C3D = 5'd16;
  localparam logic [4:0] STP_C4M = 5'd17;
  localparam logic [4:0] STP_C4D = 5'd18;
  localparam logic [4:0] STP_C5M = 5'd19;
  localparam logic [4:0] STP_MAP = 5'd20;
  localparam logic [4:0] STP_DA  = 5'd21;
  localparam logic [4:0] STP_M1  = 5'd22;
  localparam logic [4:0] STP_M2  = 5'd23;
  localparam logic [4:0] STP_DV  = 5'd24;

  // configuration
  logic [TICK_W-1:0] tick_q;
  logic [THR_W-1:0]  thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= TICK_RESET;
      thr_q  <= THR_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TICK: begin
          tick_q <= cfg_data_i[TICK_W-1:0];
        end
        CFG_THR: begin
          thr_q <= cfg_data_i[THR_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // control
  state_e     st_q;
  logic [4:0] step_q;
  logic       issued_q;
  logic       in_acc;
  logic       out_free;
  logic       is_mul;
  logic       is_div;
  logic       issue;
  logic       fire;
  logic       last;
  logic [4:0] nxt;

  // slot storage and working registers
  logic [POS_W-1:0]  sx_q [NUM_SLOTS];
  logic [POS_W-1:0]  sy_q [NUM_SLOTS];
  logic [HEAD_W-1:0] sh_q [NUM_SLOTS];

  logic [SLOT_IW-1:0] idx_in;
  logic               slot_ok;
  logic [SPD_W-1:0]   spd_u;
  logic [RATE_W-1:0]  rate_u;
  logic [SPD_W-1:0]   v_mag_in;
  logic [RATE_W-1:0]  w_mag_in;

  logic [SLOT_W-1:0]  slot_q;
  logic [SLOT_IW-1:0] idx_q;
  logic               vld_q;
  logic [POS_W-1:0]   x_q;
  logic [POS_W-1:0]   y_q;
  logic [HEAD_W-1:0]  h_q;
  logic [POS_W-1:0]   dx_q;
  logic [POS_W-1:0]   dy_q;
  logic [HEAD_W-1:0]  dh_q;
  logic               v_neg_q;
  logic [SPD_W-1:0]   v_mag_q;
  logic               w_neg_q;
  logic [RATE_W-1:0]  w_mag_q;
  logic [TICK_W-1:0]  tk_q;
  logic               straight_q;
  logic               pass_q;
  logic               ax_q;
  logic               sgn_q;
  logic [31:0]        ang_q;
  logic [25:0]        p_q;
  logic [29:0]        xr_q;
  logic [29:0]        x2_q;
  logic [30:0]        t_q;
  logic [30:0]        tmp_q;
  logic [30:0]        sv_q;
  logic [30:0]        cv_q;
  logic [31:0]        s0_q;
  logic [31:0]        c0_q;
  logic [31:0]        s1_q;
  logic [31:0]        c1_q;
  logic [PROD_W-1:0]  pr_q;

  logic [POS_W-1:0]  nx;
  logic [POS_W-1:0]  ny;
  logic [HEAD_W-1:0] nh;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [2:0]        oct;
  logic [29:0]       phi;
  logic [31:0]       sp;
  logic [31:0]       sn_neg;
  logic [31:0]       cp;
  logic [31:0]       cn_neg;
  logic [31:0]       sn;
  logic [31:0]       cs;
  logic [32:0]       diff;
  logic [31:0]       dmag;
  logic [PROD_W-1:0] mres;
  logic [PROD_W-1:0] xr_rnd;
  logic [DIV_NW-1:0] dq;
  logic [31:0]       dsig;

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;

  assign idx_in   = SLOT_IW'(robot_slot_i);
  assign slot_ok  = ({30'd0, robot_slot_i} < 32'(NUM_SLOTS));
  assign spd_u    = speed_i;
  assign rate_u   = turn_rate_i;
  assign v_mag_in = spd_u[SPD_W-1] ? (SPD_W'(0) - spd_u) : spd_u;
  assign w_mag_in = rate_u[RATE_W-1] ? (RATE_W'(0) - rate_u) : rate_u;

  // octant reduction and sign mapping of the series results
  assign oct    = ang_q[31:29];
  assign phi    = oct[0] ? (30'h2000_0000 - {1'b0, ang_q[28:0]}) : {1'b0, ang_q[28:0]};
  assign sp     = {1'b0, sv_q};
  assign cp     = {1'b0, cv_q};
  assign sn_neg = 32'd0 - sp;
  assign cn_neg = 32'd0 - cp;

  always_comb begin
    unique case (oct)
      3'd0:    begin sn = sp;     cs = cp;     end
      3'd1:    begin sn = cp;     cs = sp;     end
      3'd2:    begin sn = cp;     cs = sn_neg; end
      3'd3:    begin sn = sp;     cs = cn_neg; end
      3'd4:    begin sn = sn_neg; cs = cn_neg; end
      3'd5:    begin sn = cn_neg; cs = sn_neg; end
      3'd6:    begin sn = cn_neg; cs = sp;     end
      default: begin sn = sn_neg; cs = cp;     end
    endcase
  end

  // factor that multiplies the speed for the current axis
  always_comb begin
    priority if (straight_q) begin
      diff = ax_q ? {s0_q[31], s0_q} : {c0_q[31], c0_q};
    end else if (!ax_q) begin
      diff = {s1_q[31], s1_q} - {s0_q[31], s0_q};
    end else begin
      diff = {c0_q[31], c0_q} - {c1_q[31], c1_q};
    end
  end
  assign dmag = diff[32] ? (32'd0 - diff[31:0]) : diff[31:0];

  assign mres   = mul_rsp.prod;
  assign xr_rnd = mres + RND_SIN;
  assign dq     = div_rsp.quo;
  assign dsig   = sgn_q ? (32'd0 - dq[31:0]) : dq[31:0];

  // step decode: unit, operands and successor
  always_comb begin
    is_mul    = 1'b0;
    is_div    = 1'b0;
    mul_req.a = '0;
    mul_req.b = '0;
    div_req.n = '0;
    div_req.d = '0;
    nxt       = step_q + 5'd1;
    last      = 1'b0;
    unique case (step_q)
      STP_WT: begin
        is_mul = 1'b1; mul_req.a = MUL_AW'(w_mag_q); mul_req.b = MUL_BW'(tk_q);
      end
      STP_DH: begin
        is_div = 1'b1; div_req.n = (DIV_NW'(p_q) << 4) + RND_5625; div_req.d = K_5625;
      end
      STP_X: begin
        is_mul = 1'b1; mul_req.a = MUL_AW'(phi); mul_req.b = HALF_PI_Q32;
      end
      STP_X2: begin
        is_mul = 1'b1; mul_req.a = MUL_AW'(xr_q); mul_req.b = MUL_BW'(xr_q);
      end
      STP_S1:  begin is_div = 1'b1; div_req.n = DIV_NW'(x2_q);  div_req.d = K_72; end
      STP_S2D: begin is_div = 1'b1; div_req.n = DIV_NW'(tmp_q); div_req.d = K_42; end
      STP_S3D: begin is_div = 1'b1; div_req.n = DIV_NW'(tmp_q); div_req.d = K_20; end
      STP_S4D: begin is_div = 1'b1; div_req.n = DIV_NW'(tmp_q); div_req.d = K_6;  end
      STP_C1:  begin is_div = 1'b1; div_req.n = DIV_NW'(x2_q);  div_req.d = K_90; end
      STP_C2D: begin is_div = 1'b1; div_req.n = DIV_NW'(tmp_q); div_req.d = K_56; end
      STP_C3D: begin is_div = 1'b1; div_req.n = DIV_NW'(tmp_q); div_req.d = K_30; end
      STP_C4D: begin is_div = 1'b1; div_req.n = DIV_NW'(tmp_q); div_req.d = K_12; end
      STP_S2M, STP_S3M, STP_S4M, STP_C2M, STP_C3M, STP_C4M, STP_C5M: begin
        is_mul = 1'b1; mul_req.a = MUL_AW'(x2_q); mul_req.b = MUL_BW'(t_q);
      end
      STP_SIN: begin
        is_mul = 1'b1; mul_req.a = MUL_AW'(xr_q); mul_req.b = MUL_BW'(t_q);
      end
      STP_MAP: begin
        if (pass_q || straight_q) nxt = STP_M1;
      end
      STP_DA: begin
        is_div = 1'b1; div_req.n = (DIV_NW'(p_q) << 20) + RND_5625; div_req.d = K_5625;
        nxt = STP_X;
      end
      STP_M1: begin
        is_mul = 1'b1; mul_req.a = MUL_AW'(v_mag_q); mul_req.b = MUL_BW'(dmag);
      end
      STP_M2: begin
        is_mul = 1'b1; mul_req.a = pr_q[MUL_AW-1:0];
        mul_req.b = straight_q ? MUL_BW'(tk_q) : NINETY_PI;
      end
      STP_DV: begin
        is_div = 1'b1;
        if (straight_q) begin
          div_req.n = DIV_NW'((pr_q + RND_STR) >> 25);
          div_req.d = K_125;
        end else begin
          div_req.n = DIV_NW'((pr_q + (PROD_W'(w_mag_q) << 26)) >> 27);
          div_req.d = w_mag_q;
        end
        nxt  = STP_M1;
        last = ax_q;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  assign issue         = (st_q == ST_CALC) && !issued_q && (is_mul || is_div);
  assign mul_req.start = issue && is_mul;
  assign div_req.start = issue && is_div;
  assign fire = (st_q == ST_CALC) &&
                ((!is_mul && !is_div) || (issued_q && (mul_rsp.done || div_rsp.done)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      step_q   <= STP_WT;
      issued_q <= 1'b0;
    end else begin
      unique case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            st_q     <= ((opcode_i == OP_ADVANCE) && slot_ok) ? ST_CALC : ST_FIN;
            step_q   <= STP_WT;
            issued_q <= 1'b0;
          end
        end
        ST_CALC: begin
          if (issue) issued_q <= 1'b1;
          if (fire) begin
            issued_q <= 1'b0;
            step_q   <= nxt;
            if (last) st_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q     <= robot_slot_i;
      idx_q      <= idx_in;
      vld_q      <= slot_ok;
      dx_q       <= '0;
      dy_q       <= '0;
      dh_q       <= '0;
      v_neg_q    <= spd_u[SPD_W-1];
      v_mag_q    <= v_mag_in;
      w_neg_q    <= rate_u[RATE_W-1];
      w_mag_q    <= w_mag_in;
      tk_q       <= tick_q;
      straight_q <= (rate_u == '0) || (w_mag_in < {1'b0, thr_q});
      pass_q     <= 1'b0;
      ax_q       <= 1'b0;
      if (!slot_ok) begin
        x_q   <= '0;
        y_q   <= '0;
        h_q   <= '0;
        ang_q <= '0;
      end else if (opcode_i == OP_PLACE) begin
        x_q   <= place_x_i;
        y_q   <= place_y_i;
        h_q   <= place_heading_i;
        ang_q <= '0;
      end else begin
        x_q   <= sx_q[idx_in];
        y_q   <= sy_q[idx_in];
        h_q   <= sh_q[idx_in];
        ang_q <= {sh_q[idx_in], 16'd0};
      end
    end else if (fire) begin
      unique case (step_q)
        STP_WT:  p_q  <= mres[25:0];
        STP_DH:  dh_q <= w_neg_q ? (16'd0 - dq[15:0]) : dq[15:0];
        STP_X:   xr_q <= xr_rnd[61:32];
        STP_X2:  x2_q <= mres[59:30];
        STP_S1, STP_S2D, STP_S3D, STP_S4D, STP_C1, STP_C2D, STP_C3D, STP_C4D: begin
          t_q <= ONE_Q30 - dq[30:0];
        end
        STP_S2M, STP_S3M, STP_S4M, STP_C2M, STP_C3M, STP_C4M: begin
          tmp_q <= mres[60:30];
        end
        STP_SIN: sv_q <= mres[60:30];
        STP_C5M: cv_q <= ONE_Q30 - mres[61:31];
        STP_MAP: begin
          if (pass_q) begin
            s1_q <= sn;
            c1_q <= cs;
          end else begin
            s0_q <= sn;
            c0_q <= cs;
          end
        end
        STP_DA: begin
          ang_q  <= {h_q, 16'd0} + (w_neg_q ? (32'd0 - dq[31:0]) : dq[31:0]);
          pass_q <= 1'b1;
        end
        STP_M1: begin
          pr_q  <= mres;
          sgn_q <= v_neg_q ^ diff[32] ^ (!straight_q && w_neg_q);
        end
        STP_M2: pr_q <= mres;
        STP_DV: begin
          if (ax_q) dy_q <= dsig;
          else dx_q <= dsig;
          ax_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign nx = x_q + dx_q;
  assign ny = y_q + dy_q;
  assign nh = h_q + dh_q;

  // slot storage, written back when the result is handed over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        sx_q[i] <= slot_x_rst(i);
        sy_q[i] <= '0;
        sh_q[i] <= slot_h_rst(i);
      end
    end else if ((st_q == ST_FIN) && out_free && vld_q) begin
      sx_q[idx_q] <= nx;
      sy_q[idx_q] <= ny;
      sh_q[idx_q] <= nh;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((st_q == ST_FIN) && out_free) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((st_q == ST_FIN) && out_free) begin
      result_slot_o  <= slot_q;
      pose_x_o       <= nx;
      pose_y_o       <= ny;
      pose_heading_o <= nh;
    end
  end

  ddpi_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  ddpi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

`ifndef SYNTHESIS
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_rsp.done && div_rsp.done))
    else $error("multiplier and divider finished together");

  a_mul_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (st_q == ST_CALC) && issued_q && is_mul)
    else $error("multiplier result with no step waiting for it");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (st_q == ST_CALC) && issued_q && is_div)
    else $error("divider result with no step waiting for it");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FIN) && out_free |=> out_valid_o && (st_q == ST_IDLE))
    else $error("finished word not presented");
`endif

endmodule

>>> dv/differential_drive_pose_integrator_unit_test.sv
module differential_drive_pose_integrator_unit_test;
  import ddpi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    opcode_e                  op;
    logic [SLOT_W-1:0]        slot;
    logic signed [SPD_W-1:0]  speed;
    logic signed [RATE_W-1:0] turn;
    logic [POS_W-1:0]         px;
    logic [POS_W-1:0]         py;
    logic [HEAD_W-1:0]        ph;
  } step_word_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [HEAD_W-1:0] heading;
  } pose_t;

  localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_SPARE  = 2'd3;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IW-1:0]        cfg_index_i;
  logic [CFG_DW-1:0]        cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [0:0]               opcode_i;
  logic [SLOT_W-1:0]        robot_slot_i;
  logic signed [SPD_W-1:0]  speed_i;
  logic signed [RATE_W-1:0] turn_rate_i;
  logic signed [POS_W-1:0]  place_x_i;
  logic signed [POS_W-1:0]  place_y_i;
  logic [HEAD_W-1:0]        place_heading_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [SLOT_W-1:0]        result_slot_o;
  logic signed [POS_W-1:0]  pose_x_o;
  logic signed [POS_W-1:0]  pose_y_o;
  logic [HEAD_W-1:0]        pose_heading_o;

  differential_drive_pose_integrator_unit i_dut (.*);

  // predictor state
  logic [POS_W-1:0]  pred_x [NUM_SLOTS_DEF];
  logic [POS_W-1:0]  pred_y [NUM_SLOTS_DEF];
  logic [HEAD_W-1:0] pred_h [NUM_SLOTS_DEF];
  logic [TICK_W-1:0] pred_tick;
  logic [THR_W-1:0]  pred_thr;

  pose_t pose_q[$];
  int    mismatches;
  bit    steady;
  int    out_stall;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("differential_drive_pose_integrator_unit_test NOT OK");
    $finish;
  end

  function automatic longint round_div(longint n, longint d);
    bit [63:0] mn, md, q;
    mn = n < 0 ? -n : n;
    md = d < 0 ? -d : d;
    q  = (mn + md / 2) / md;
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  task automatic sin_cos(input bit [31:0] a, output longint sn, output longint cs);
    bit [2:0]  oct;
    bit [63:0] phi, x, x2, t, s, c;
    oct = a[31:29];
    phi = a[28:0];
    if (oct[0]) phi = (64'd1 << 29) - phi;
    x  = (phi * 64'd6746518852 + (64'd1 << 31)) >> 32;
    x2 = (x * x) >> 30;
    t = 64'(ONE_Q30) - x2 / 72;
    t = 64'(ONE_Q30) - ((x2 * t) >> 30) / 42;
    t = 64'(ONE_Q30) - ((x2 * t) >> 30) / 20;
    t = 64'(ONE_Q30) - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    t = 64'(ONE_Q30) - x2 / 90;
    t = 64'(ONE_Q30) - ((x2 * t) >> 30) / 56;
    t = 64'(ONE_Q30) - ((x2 * t) >> 30) / 30;
    t = 64'(ONE_Q30) - ((x2 * t) >> 30) / 12;
    c = 64'(ONE_Q30) - ((x2 * t) >> 30) / 2;
    case (oct)
      3'd0: begin sn = s;  cs = c;  end
      3'd1: begin sn = c;  cs = s;  end
      3'd2: begin sn = c;  cs = -longint'(s); end
      3'd3: begin sn = s;  cs = -longint'(c); end
      3'd4: begin sn = -longint'(s); cs = -longint'(c); end
      3'd5: begin sn = -longint'(c); cs = -longint'(s); end
      3'd6: begin sn = -longint'(c); cs = s; end
      default: begin sn = -longint'(s); cs = c; end
    endcase
  endtask

  task automatic integrate_pose(input step_word_t w);
    pose_t     p;
    bit [31:0] h32, a1;
    longint    v, r, aw, tk, dh, da, dx, dy, s0, c0, s1, c1;
    p.slot = w.slot;
    if (w.op == OP_PLACE) begin
      pred_x[w.slot] = w.px;
      pred_y[w.slot] = w.py;
      pred_h[w.slot] = w.ph;
    end else begin
      v   = longint'(w.speed);
      r   = longint'(w.turn);
      tk  = longint'(pred_tick);
      aw  = r < 0 ? -r : r;
      h32 = {pred_h[w.slot], 16'h0000};
      dh  = round_div(r * tk * 16, 5625);
      sin_cos(h32, s0, c0);
      if (r == 0 || aw < longint'(pred_thr)) begin
        dx = round_div(v * c0 * tk, 64'sd4194304000);
        dy = round_div(v * s0 * tk, 64'sd4194304000);
      end else begin
        da = round_div(r * tk * 1048576, 5625);
        a1 = h32 + da[31:0];
        sin_cos(a1, s1, c1);
        dx = round_div(v * (s1 - s0) * 64'sd117342, r * 64'sd134217728);
        dy = round_div(v * (c0 - c1) * 64'sd117342, r * 64'sd134217728);
      end
      pred_x[w.slot] = pred_x[w.slot] + dx[31:0];
      pred_y[w.slot] = pred_y[w.slot] + dy[31:0];
      pred_h[w.slot] = pred_h[w.slot] + dh[15:0];
    end
    p.x = pred_x[w.slot];
    p.y = pred_y[w.slot];
    p.heading = pred_h[w.slot];
    pose_q.push_back(p);
  endtask

  // result side: check each pose against the oldest predicted one, then draw a random stall unless steady
  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose word slot %0d", result_slot_o);
      end else begin
        e = pose_q.pop_front();
        if (e.slot !== result_slot_o || e.x !== pose_x_o || e.y !== pose_y_o ||
            e.heading !== pose_heading_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch: exp slot %0d x %h y %h h %h, got slot %0d x %h y %h h %h",
                     e.slot, e.x, e.y, e.heading, result_slot_o, pose_x_o, pose_y_o,
                     pose_heading_o);
        end
      end
      out_stall = steady ? 0 : $urandom_range(0, 15);
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_word(input step_word_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= w.op;
    robot_slot_i    <= w.slot;
    speed_i         <= w.speed;
    turn_rate_i     <= w.turn;
    place_x_i       <= w.px;
    place_y_i       <= w.py;
    place_heading_i <= w.ph;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    integrate_pose(w);
  endtask

  // hold until every pose is back, then write one register
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    in_valid_i <= 1'b0;
    wait (pose_q.size() == 0);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TICK) pred_tick = val[TICK_W-1:0];
    else if (idx == CFG_THR) pred_thr = val;
  endtask

  function automatic step_word_t mk_word(opcode_e op, int slot, int spd, int trn,
                                         int px, int py, int ph);
    step_word_t w;
    w.op = op; w.slot = SLOT_W'(slot); w.speed = SPD_W'(spd); w.turn = RATE_W'(trn);
    w.px = px; w.py = py; w.ph = HEAD_W'(ph);
    return w;
  endfunction

  function automatic step_word_t rand_word();
    step_word_t w;
    int         k;
    k = $urandom_range(0, 99);
    w.op    = (k < 8) ? OP_PLACE : OP_ADVANCE;
    w.slot  = SLOT_W'($urandom_range(0, 3));
    w.speed = SPD_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                  : $urandom_range(0, 4096) - 2048);
    case ($urandom_range(0, 3))
      0: w.turn = RATE_W'($urandom);
      1: w.turn = RATE_W'($urandom_range(0, 2 * pred_thr + 2) - pred_thr - 1);
      2: w.turn = 0;
      default: w.turn = RATE_W'($urandom_range(0, 20000) - 10000);
    endcase
    w.px = $urandom;
    w.py = $urandom;
    w.ph = HEAD_W'($urandom);
    return w;
  endfunction

  task automatic test_reset_poses();
    for (int s = 0; s < 4; s++) send_word(mk_word(OP_ADVANCE, s, 0, 0, 0, 0, 0));
  endtask

  task automatic test_directed();
    send_word(mk_word(OP_PLACE, 2, 32767, -32768, 32'h7fffffff, 32'h80000000, 16'hffff));
    send_word(mk_word(OP_ADVANCE, 2, 32767, 0, 0, 0, 0));
    send_word(mk_word(OP_ADVANCE, 2, -32768, 639, 0, 0, 0));
    send_word(mk_word(OP_ADVANCE, 2, -32768, 640, 0, 0, 0));
    send_word(mk_word(OP_ADVANCE, 0, 32767, -32768, 0, 0, 0));
    send_word(mk_word(OP_ADVANCE, 1, 256, 32767, 0, 0, 0));
    send_word(mk_word(OP_ADVANCE, 3, -1, -640, 0, 0, 0));
    send_word(mk_word(OP_PLACE, 3, 0, 0, 32'h80000000, 32'h7fffffff, 16'h0000));
    send_word(mk_word(OP_ADVANCE, 3, 32767, 1, 0, 0, 0));
  endtask

  task automatic test_tick_extremes();
    write_reg(CFG_TICK, 15'd0);
    send_word(mk_word(OP_ADVANCE, 0, 32767, 32767, 0, 0, 0));
    write_reg(CFG_TICK, 15'd1023);
    write_reg(CFG_THR, 15'd0);
    send_word(mk_word(OP_ADVANCE, 1, 32767, 0, 0, 0, 0));
    send_word(mk_word(OP_ADVANCE, 1, -32768, -1, 0, 0, 0));
    write_reg(CFG_THR, 15'h7fff);
    send_word(mk_word(OP_ADVANCE, 2, 1000, -32768, 0, 0, 0));
    send_word(mk_word(OP_ADVANCE, 2, 1000, 32767, 0, 0, 0));
    // unknown index must leave both registers alone
    write_reg(CFG_UNUSED, 15'h7fff);
    write_reg(CFG_SPARE, 15'h0000);
    send_word(mk_word(OP_ADVANCE, 0, 500, 20000, 0, 0, 0));
    write_reg(CFG_TICK, 15'd1);
    write_reg(CFG_THR, 15'd1);
    send_word(mk_word(OP_ADVANCE, 0, -500, 1, 0, 0, 0));
  endtask

  task automatic test_random_phases();
    int ticks [6] = '{10, 1000, 1, 37, 250, 1023};
    int thrs  [6] = '{640, 0, 32767, 1, 5000, 200};
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_TICK, CFG_DW'(ticks[p]));
      write_reg(CFG_THR, CFG_DW'(thrs[p]));
      for (int i = 0; i < 305; i++) begin
        steady = (i % 100) >= 80;
        send_word(rand_word());
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    opcode_i        = '0;
    robot_slot_i    = '0;
    speed_i         = '0;
    turn_rate_i     = '0;
    place_x_i       = '0;
    place_y_i       = '0;
    place_heading_i = '0;
    out_ready_i     = 1'b0;
    mismatches      = 0;
    steady          = 1'b0;
    out_stall       = 0;
    pred_tick       = TICK_RESET;
    pred_thr        = THR_RESET;
    for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
      pred_x[s] = slot_x_rst(s);
      pred_y[s] = '0;
      pred_h[s] = slot_h_rst(s);
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_poses();
    test_directed();
    test_tick_extremes();
    test_random_phases();
    in_valid_i <= 1'b0;
    wait (pose_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("differential_drive_pose_integrator_unit_test OK");
    end else begin
      $display("differential_drive_pose_integrator_unit_test NOT OK");
    end
    $finish;
  end

endmodule
